// ===== design/psg_pkg.sv =====
package psg_pkg;

  localparam int MaxGuides = 16;
  localparam int GuideAw   = (MaxGuides > 1) ? $clog2(MaxGuides) : 1;
  localparam int WalkW     = (GuideAw + 2 > 6) ? GuideAw + 2 : 6;
  localparam int DivSteps  = 32;
  localparam int DivCntW   = $clog2(DivSteps);
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 31;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_SPACING  = 3'd0,
    CFG_GRID_SUBDIV   = 3'd1,
    CFG_CANVAS_WIDTH  = 3'd2,
    CFG_CANVAS_HEIGHT = 3'd3,
    CFG_SNAP_THRESH   = 3'd4,
    CFG_GUIDE_COUNT   = 3'd5
  } cfg_idx_e;

  localparam logic MODE_GUIDE_WR = 1'b0;
  localparam logic MODE_SNAP     = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [3:0]        guide_index;
    logic              guide_vertical;
    logic signed [31:0] guide_position;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] snapped_x;
    logic signed [31:0] snapped_y;
    logic              hit_x;
    logic              hit_y;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MINOR,
    ST_GSTART,
    ST_GRID,
    ST_ROUND,
    ST_MERGE
  } state_e;

  typedef struct packed {
    logic guide_wr;
    logic load;
    logic grid_start;
    logic round;
    logic merge;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

// ===== design/psg_div.sv =====
module psg_div
  import psg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [30:0] rem_o
);

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [31:0]        dvd_q, dvd_d;
  logic [30:0]        rem_q, rem_d;
  logic [30:0]        dsr_q, dsr_d;
  logic [32:0]        trial;
  logic               last;

  // restoring step: quotient bits shift into the dividend register
  assign trial = {1'b0, rem_q, dvd_q[31]} - {2'b0, dsr_q};
  assign last  = busy_q && (cnt_q == DivCntW'(DivSteps - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + DivCntW'(1);
      if (!trial[32]) begin
        rem_d = trial[30:0];
        dvd_d = {dvd_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[29:0], dvd_q[31]};
        dvd_d = {dvd_q[30:0], 1'b0};
      end
      if (last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = last;
  assign quo_o  = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/psg_ctrl.sv =====
module psg_ctrl
  import psg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_mode_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && in_mode_i == MODE_SNAP) state_d = ST_MINOR;
      ST_MINOR:  if (status_i.div_done) state_d = ST_GSTART;
      ST_GSTART: state_d = ST_GRID;
      ST_GRID:   if (status_i.div_done) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_MERGE;
      ST_MERGE:  if (status_i.walk_done && status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.guide_wr = in_valid_i && (in_mode_i == MODE_GUIDE_WR);
        cmd_o.load     = in_valid_i && (in_mode_i == MODE_SNAP);
      end
      ST_GSTART: cmd_o.grid_start = 1'b1;
      ST_ROUND:  cmd_o.round = 1'b1;
      ST_MERGE:  cmd_o.merge = status_i.walk_done && status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

// ===== design/psg_dpath.sv =====
module psg_dpath
  import psg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_t                 in_data_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  // configuration
  logic [30:0] spacing_q, width_q, height_q, thr_q;
  logic [7:0]  subdiv_q;
  logic [4:0]  gcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= '0;
      subdiv_q  <= 8'd1;
      width_q   <= '0;
      height_q  <= '0;
      thr_q     <= '0;
      gcount_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_SPACING:  spacing_q <= cfg_data_i;
        CFG_GRID_SUBDIV:   subdiv_q  <= cfg_data_i[7:0];
        CFG_CANVAS_WIDTH:  width_q   <= cfg_data_i;
        CFG_CANVAS_HEIGHT: height_q  <= cfg_data_i;
        CFG_SNAP_THRESH:   thr_q     <= cfg_data_i;
        CFG_GUIDE_COUNT:   gcount_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] diff;
    logic [32:0]        mag;
    diff = 33'(a) - 33'(b);
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
    return mag[31:0];
  endfunction

  // {hit, value} for one axis
  function automatic logic [32:0] pick(logic signed [31:0] p, logic gen, logic [32:0] gc,
                                       logic [30:0] gd, logic [30:0] thr, logic bh,
                                       logic [31:0] bd, logic signed [31:0] bc);
    logic        hg;
    logic        use_b;
    logic [31:0] gsat;
    hg    = gen && (gd <= thr);
    use_b = bh && (!hg || (bd <= {1'b0, gd}));
    if (p[31]) gsat = (gc > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-gc[31:0]);
    else       gsat = (gc > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : gc[31:0];
    if (use_b)   return {1'b1, bc};
    else if (hg) return {1'b1, gsat};
    else         return {1'b0, p};
  endfunction

  // item registers
  logic signed [31:0] px_q, py_q;
  logic               en_q;
  logic [31:0]        ax, ay;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= in_data_i.point_x;
      py_q <= in_data_i.point_y;
      en_q <= (thr_q != '0);
    end
  end

  assign ax = px_q[31] ? 32'(-px_q) : 32'(px_q);
  assign ay = py_q[31] ? 32'(-py_q) : 32'(py_q);

  // guide table
  logic [32:0]        guide_mem [MaxGuides];
  logic [32:0]        rd_q;
  logic [WalkW-1:0]   idx_q, idx_d, n_q, n_d, rd_idx;
  logic               walk_q, walk_d;

  assign rd_idx = idx_q - WalkW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.guide_wr && (32'(in_data_i.guide_index) < MaxGuides))
      guide_mem[GuideAw'(in_data_i.guide_index)] <=
        {in_data_i.guide_vertical, in_data_i.guide_position};
    rd_q <= guide_mem[rd_idx[GuideAw-1:0]];
  end

  // edge and guide walk, runs while the divider works; grid merged at the end
  logic signed [31:0] bxc_q, bxc_d, byc_q, byc_d;
  logic [31:0]        bxd_q, bxd_d, byd_q, byd_d;
  logic               bxh_q, bxh_d, byh_q, byh_d;
  logic signed [31:0] cand_x, cand_y;
  logic               use_x, use_y;
  logic [31:0]        dx, dy;

  always_comb begin
    cand_x = '0;
    cand_y = '0;
    use_x  = 1'b1;
    use_y  = 1'b1;
    if (idx_q == WalkW'(1)) begin
      cand_x = 32'(width_q);
      cand_y = 32'(height_q);
    end else if (idx_q >= WalkW'(2)) begin
      cand_x = rd_q[31:0];
      cand_y = rd_q[31:0];
      use_x  = rd_q[32];
      use_y  = !rd_q[32];
    end
  end

  assign dx = abs_diff(cand_x, px_q);
  assign dy = abs_diff(cand_y, py_q);

  always_comb begin
    walk_d = walk_q;
    idx_d  = idx_q;
    n_d    = n_q;
    bxc_d  = bxc_q;
    bxd_d  = bxd_q;
    bxh_d  = bxh_q;
    byc_d  = byc_q;
    byd_d  = byd_q;
    byh_d  = byh_q;
    if (cmd_i.load) begin
      walk_d = 1'b1;
      idx_d  = '0;
      n_d    = (32'(gcount_q) > MaxGuides) ? WalkW'(MaxGuides) : WalkW'(gcount_q);
      bxd_d  = {1'b0, thr_q};
      byd_d  = {1'b0, thr_q};
      bxh_d  = 1'b0;
      byh_d  = 1'b0;
    end else if (walk_q) begin
      idx_d = idx_q + WalkW'(1);
      if (idx_q == n_q + WalkW'(1)) walk_d = 1'b0;
      if (en_q && use_x && (dx <= bxd_q)) begin
        bxc_d = cand_x;
        bxd_d = dx;
        bxh_d = 1'b1;
      end
      if (en_q && use_y && (dy <= byd_q)) begin
        byc_d = cand_y;
        byd_d = dy;
        byh_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) walk_q <= 1'b0;
    else         walk_q <= walk_d;
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    n_q   <= n_d;
    bxc_q <= bxc_d;
    bxd_q <= bxd_d;
    bxh_q <= bxh_d;
    byc_q <= byc_d;
    byd_q <= byd_d;
    byh_q <= byh_d;
  end

  // dividers: x unit first yields the minor step, then both take |p| / minor
  logic        done_x, done_y;
  logic [31:0] quo_x, quo_y;
  logic [30:0] rem_x, rem_y;
  logic [31:0] dvd_x;
  logic [30:0] dsr_x;

  assign dvd_x = cmd_i.load ? {1'b0, spacing_q} : ax;
  assign dsr_x = cmd_i.load ? {23'b0, subdiv_q} : quo_x[30:0];

  psg_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load | cmd_i.grid_start),
    .dividend_i (dvd_x),
    .divisor_i  (dsr_x),
    .done_o     (done_x),
    .quo_o      (quo_x),
    .rem_o      (rem_x)
  );

  psg_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.grid_start),
    .dividend_i (ay),
    .divisor_i  (quo_x[30:0]),
    .done_o     (done_y),
    .quo_o      (quo_y),
    .rem_o      (rem_y)
  );

  logic [30:0] minor_q;
  logic        gen_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.grid_start) begin
      minor_q <= quo_x[30:0];
      gen_q   <= en_q && (subdiv_q != '0) && (quo_x[30:0] != '0);
    end
  end

  // rounded magnitude = a - r (+ minor when 2r >= minor); quotient bits not needed
  logic        rnd_x, rnd_y;
  logic [32:0] gcx_q, gcy_q;
  logic [30:0] gdx_q, gdy_q;

  assign rnd_x = {rem_x, 1'b0} >= {1'b0, minor_q};
  assign rnd_y = {rem_y, 1'b0} >= {1'b0, minor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      gcx_q <= {1'b0, ax} - {2'b0, rem_x} + (rnd_x ? {2'b0, minor_q} : 33'd0);
      gcy_q <= {1'b0, ay} - {2'b0, rem_y} + (rnd_y ? {2'b0, minor_q} : 33'd0);
      gdx_q <= rnd_x ? (minor_q - rem_x) : rem_x;
      gdy_q <= rnd_y ? (minor_q - rem_y) : rem_y;
    end
  end

  // output register
  logic        out_valid_q;
  out_t        out_q;
  logic [32:0] res_x, res_y;

  assign res_x = pick(px_q, gen_q, gcx_q, gdx_q, thr_q, bxh_q, bxd_q, bxc_q);
  assign res_y = pick(py_q, gen_q, gcy_q, gdy_q, thr_q, byh_q, byd_q, byc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                      out_valid_q <= 1'b0;
    else if (cmd_i.merge)             out_valid_q <= 1'b1;
    else if (out_ready_i)             out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.merge) begin
      out_q.snapped_x <= res_x[31:0];
      out_q.snapped_y <= res_y[31:0];
      out_q.hit_x     <= res_x[32];
      out_q.hit_y     <= res_y[32];
    end
  end

  assign status_o.div_done  = done_x | done_y;
  assign status_o.walk_done = !walk_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

// ===== design/point_snap_to_grid_and_guides.sv =====
// Point snapper: per-axis snap of a point to grid, canvas edges and guides.
// Input channel (in_valid_i/in_ready_o, in_data_i): a mode-0 item writes one
// guide table entry in its accept cycle and gives no result; a mode-1 item
// snaps point_x/point_y and gives one result on the output channel
// (out_valid_o/out_ready_i, out_data_o).
// A snap item runs through these steps: a radix-2 divider finds the minor grid
// step, a start state follows, |x| and |y| are divided by that step (two
// divider units side by side), then a rounding state and a merge state. The
// edge and guide walk (one guide per cycle from the table memory) overlaps the
// division. One snap item is in work at a time; the next is accepted the cycle
// after the result is written. Guide writes go one per cycle while idle.
// Results sit in an output register; while the receiver stalls the block
// still takes a new item and finishes it up to the merge, where it waits.
// Reset clears control state and loads configuration defaults (subdivisions 1,
// all others 0); guide entries are undefined until written. Configuration
// (cfg_we_i, cfg_idx_i, cfg_data_i) is to be written only while idle; the user
// must keep to this, as the block itself does not enforce it.
module point_snap_to_grid_and_guides
  import psg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  cmd_t    cmd;
  status_t status;

  psg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  psg_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
